// File: rtl/core/riea_pkg.sv
// package with opcodes, touch codes and shared types of the remote input aggregator
`timescale 1ns / 1ps
package riea_pkg;

   typedef enum logic [3:0] {
      OP_KEY       = 4'd0,
      OP_TRIM      = 4'd1,
      OP_ENCODER   = 4'd2,
      OP_TOUCH     = 4'd3,
      OP_LEVEL     = 4'd4,
      OP_DISCONN   = 4'd5,
      OP_TAKE_KEYS = 4'd6,
      OP_TAKE_TRIM = 4'd7,
      OP_TAKE_DT   = 4'd8,
      OP_READ_OFS  = 4'd9,
      OP_POP_TOUCH = 4'd10
   } opcode_type;

   localparam logic [1:0] TOUCH_DOWN = 2'd0;
   localparam logic [1:0] TOUCH_UP   = 2'd1;

   localparam logic [1:0] REG_RELEASE = 2'd0;
   localparam logic [1:0] REG_ENC_DT  = 2'd1;
   localparam logic [1:0] REG_WIDTH   = 2'd2;
   localparam logic [1:0] REG_HEIGHT  = 2'd3;

   localparam int COORD_BITS = 15;

   // touch transition ring, power of two so the slot is the low sequence bits
   localparam int RING_DEPTH = 8;
   localparam int RING_BITS  = 3;

   typedef struct packed {
      logic [COORD_BITS-1:0] y;
      logic [COORD_BITS-1:0] x;
   } point_type;

   typedef struct packed {
      logic      pressed;
      point_type pt;
   } sample_type;

   function automatic logic [COORD_BITS-1:0] clamp_coord(
      input logic signed [15:0] raw, input logic [15:0] limit);
      logic [15:0] lm1;
      begin
         lm1 = limit - 16'd1;
         if (raw[15] || limit == 16'd0) clamp_coord = '0;
         else if ({1'b0, raw[14:0]} >= limit) clamp_coord = lm1[COORD_BITS-1:0];
         else clamp_coord = raw[14:0];
      end
   endfunction

endpackage

// File: rtl/core/riea_core.sv
// state registers and combinational next-state update of the remote input aggregator
`timescale 1ns / 1ps
module riea_core #(
   parameter int MASK_BITS  = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  logic [3:0]  op,
   input  logic [7:0]  bit_index,
   input  logic        is_pressed,
   input  logic signed [7:0] enc_steps,
   input  logic [1:0]  touch_event,
   input  logic signed [15:0] coord_x,
   input  logic signed [15:0] coord_y,
   input  logic [31:0] keys_level,
   input  logic [31:0] trims_level,
   input  logic        finger_down,
   input  logic [31:0] now_ms,
   input  logic [15:0] release_timeout_ms,
   input  logic [15:0] encoder_idle_dt_ms,
   input  logic [15:0] screen_width,
   input  logic [15:0] screen_height,
   output logic [31:0] mask_out,
   output logic signed [31:0] enc_offset,
   output logic [31:0] dt_out,
   output logic        touch_valid,
   output riea_pkg::sample_type touch_sample
);
   localparam int RW = riea_pkg::RING_BITS;
   localparam logic [31:0] RD = 32'(riea_pkg::RING_DEPTH);

   logic [31:0] keys_held_ff, keys_held_in, keys_lat_ff, keys_lat_in;
   logic [31:0] trims_held_ff, trims_held_in, trims_lat_ff, trims_lat_in;
   logic [31:0] enc_accum_ff, enc_accum_in, enc_dt_ff, enc_dt_in;
   logic        link_active_ff, link_active_in;
   logic [31:0] last_pkt_ff, last_pkt_in, epoch_ff, epoch_in, drop_seq_ff, drop_seq_in;
   riea_pkg::point_type latest_ff, latest_in, cons_pt_ff, cons_pt_in;
   logic [31:0] touch_seq_ff, touch_seq_in;
   riea_pkg::sample_type ring_ff [riea_pkg::RING_DEPTH];
   logic        prod_down_ff, prod_down_in;
   logic [31:0] last_click_ff, last_click_in;
   logic        has_click_ff, has_click_in;
   logic [31:0] seen_epoch_ff, seen_epoch_in, taken_ff, taken_in;
   logic        cons_down_ff, cons_down_in;

   logic        push;
   riea_pkg::sample_type push_s;
   logic        lost;
   logic [31:0] el, dt, taken_v;
   logic [31:0] bitm;
   logic [14:0] cx, cy;

   assign lost = !link_active_ff || ((now_ms - last_pkt_ff) > {16'd0, release_timeout_ms});
   assign cx = riea_pkg::clamp_coord(coord_x, screen_width);
   assign cy = riea_pkg::clamp_coord(coord_y, screen_height);
   assign el = now_ms - last_click_ff;
   assign dt = (has_click_ff && el < {16'd0, encoder_idle_dt_ms}) ? el
             : {16'd0, encoder_idle_dt_ms};

   always_comb begin
      bitm = '0;
      if ({24'd0, bit_index} < 32'(MASK_BITS)) bitm = 32'd1 << bit_index;
   end

   always_comb begin
      keys_held_in = keys_held_ff; keys_lat_in = keys_lat_ff;
      trims_held_in = trims_held_ff; trims_lat_in = trims_lat_ff;
      enc_accum_in = enc_accum_ff; enc_dt_in = enc_dt_ff;
      link_active_in = link_active_ff; last_pkt_in = last_pkt_ff;
      epoch_in = epoch_ff; drop_seq_in = drop_seq_ff;
      latest_in = latest_ff; touch_seq_in = touch_seq_ff;
      prod_down_in = prod_down_ff; last_click_in = last_click_ff;
      has_click_in = has_click_ff; seen_epoch_in = seen_epoch_ff;
      taken_in = taken_ff; cons_down_in = cons_down_ff; cons_pt_in = cons_pt_ff;
      push = 1'b0; push_s = '0; taken_v = taken_ff;
      mask_out = '0; enc_offset = '0; dt_out = '0; touch_valid = 1'b0;
      touch_sample = '0;
      case (op)
         riea_pkg::OP_KEY, riea_pkg::OP_TRIM: begin
            link_active_in = 1'b1; last_pkt_in = now_ms;
            if (op == riea_pkg::OP_KEY) begin
               if (is_pressed) begin
                  keys_held_in = keys_held_ff | bitm; keys_lat_in = keys_lat_ff | bitm;
               end else keys_held_in = keys_held_ff & ~bitm;
            end else begin
               if (is_pressed) begin
                  trims_held_in = trims_held_ff | bitm; trims_lat_in = trims_lat_ff | bitm;
               end else trims_held_in = trims_held_ff & ~bitm;
            end
         end
         riea_pkg::OP_ENCODER: begin
            link_active_in = 1'b1; last_pkt_in = now_ms;
            if (enc_steps != 8'sd0) begin
               last_click_in = now_ms; has_click_in = 1'b1;
               enc_dt_in = enc_dt_ff + dt;
               enc_accum_in = enc_accum_ff + 32'(enc_steps);
            end
         end
         riea_pkg::OP_TOUCH, riea_pkg::OP_LEVEL: begin
            if (lost) begin
               prod_down_in = 1'b0; drop_seq_in = touch_seq_ff; epoch_in = epoch_ff + 32'd1;
            end
            link_active_in = 1'b1; last_pkt_in = now_ms;
            if (op == riea_pkg::OP_TOUCH) begin
               latest_in = '{y: cy, x: cx};
               if ((touch_event == riea_pkg::TOUCH_DOWN || touch_event == riea_pkg::TOUCH_UP)
                   && ((touch_event == riea_pkg::TOUCH_DOWN) != prod_down_in)) begin
                  prod_down_in = (touch_event == riea_pkg::TOUCH_DOWN);
                  push = 1'b1;
                  push_s = '{pressed: prod_down_in, pt: '{y: cy, x: cx}};
               end
            end else begin
               keys_held_in = keys_level;
               trims_held_in = trims_level;
               if (finger_down) begin
                  latest_in = '{y: cy, x: cx};
                  if (!prod_down_in) begin
                     prod_down_in = 1'b1; push = 1'b1;
                     push_s = '{pressed: 1'b1, pt: '{y: cy, x: cx}};
                  end
               end else if (prod_down_in) begin
                  prod_down_in = 1'b0; push = 1'b1;
                  push_s = '{pressed: 1'b0, pt: latest_ff};
               end
            end
            if (push) touch_seq_in = touch_seq_ff + 32'd1;
         end
         riea_pkg::OP_DISCONN: begin
            keys_held_in = '0; keys_lat_in = '0; trims_held_in = '0; trims_lat_in = '0;
            prod_down_in = 1'b0; drop_seq_in = touch_seq_ff; epoch_in = epoch_ff + 32'd1;
            has_click_in = 1'b0; link_active_in = 1'b0;
         end
         riea_pkg::OP_TAKE_KEYS: begin
            if (lost) begin
               keys_held_in = '0; keys_lat_in = '0;
            end else begin
               mask_out = keys_held_ff | keys_lat_ff; keys_lat_in = '0;
            end
         end
         riea_pkg::OP_TAKE_TRIM: begin
            if (lost) begin
               trims_held_in = '0; trims_lat_in = '0;
            end else begin
               mask_out = trims_held_ff | trims_lat_ff; trims_lat_in = '0;
            end
         end
         riea_pkg::OP_TAKE_DT: begin
            dt_out = enc_dt_ff; enc_dt_in = '0;
         end
         riea_pkg::OP_READ_OFS: enc_offset = enc_accum_ff;
         riea_pkg::OP_POP_TOUCH: begin
            if (lost || epoch_ff != seen_epoch_ff) begin
               seen_epoch_in = epoch_ff;
               taken_v = lost ? touch_seq_ff : drop_seq_ff;
            end
            taken_in = taken_v;
            if ((lost || epoch_ff != seen_epoch_ff) && cons_down_ff) begin
               cons_down_in = 1'b0; touch_valid = 1'b1;
               touch_sample = '{pressed: 1'b0, pt: cons_pt_ff};
            end else if (!lost || epoch_ff == seen_epoch_ff) begin
               if ((touch_seq_ff - taken_v) >= RD) taken_v = touch_seq_ff - (RD - 32'd1);
               taken_in = taken_v;
               if (taken_v != touch_seq_ff) begin
                  cons_pt_in = ring_ff[taken_v[RW-1:0]].pt;
                  cons_down_in = ring_ff[taken_v[RW-1:0]].pressed;
                  taken_in = taken_v + 32'd1;
                  touch_valid = 1'b1;
                  touch_sample = '{pressed: cons_down_in, pt: cons_pt_in};
               end else if (cons_down_ff) begin
                  cons_pt_in = latest_ff; touch_valid = 1'b1;
                  touch_sample = '{pressed: 1'b1, pt: latest_ff};
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keys_held_ff <= '0; keys_lat_ff <= '0; trims_held_ff <= '0; trims_lat_ff <= '0;
         enc_accum_ff <= '0; enc_dt_ff <= '0; link_active_ff <= 1'b0; last_pkt_ff <= '0;
         epoch_ff <= '0; drop_seq_ff <= '0; latest_ff <= '0; touch_seq_ff <= '0;
         prod_down_ff <= 1'b0; last_click_ff <= '0; has_click_ff <= 1'b0;
         seen_epoch_ff <= '0; taken_ff <= '0; cons_down_ff <= 1'b0; cons_pt_ff <= '0;
         for (int i = 0; i < riea_pkg::RING_DEPTH; i++) ring_ff[i] <= '0;
      end else if (step) begin
         keys_held_ff <= keys_held_in; keys_lat_ff <= keys_lat_in;
         trims_held_ff <= trims_held_in; trims_lat_ff <= trims_lat_in;
         enc_accum_ff <= enc_accum_in; enc_dt_ff <= enc_dt_in;
         link_active_ff <= link_active_in; last_pkt_ff <= last_pkt_in;
         epoch_ff <= epoch_in; drop_seq_ff <= drop_seq_in; latest_ff <= latest_in;
         touch_seq_ff <= touch_seq_in; prod_down_ff <= prod_down_in;
         last_click_ff <= last_click_in; has_click_ff <= has_click_in;
         seen_epoch_ff <= seen_epoch_in; taken_ff <= taken_in;
         cons_down_ff <= cons_down_in; cons_pt_ff <= cons_pt_in;
         if (push) ring_ff[touch_seq_ff[RW-1:0]] <= push_s;
      end
   end

   a_epoch_step: assert property (@(posedge clock) disable iff (reset)
      step |=> (epoch_ff == $past(epoch_ff)) || (epoch_ff == $past(epoch_ff) + 32'd1))
      else $error("epoch jumped");
   a_seq_step: assert property (@(posedge clock) disable iff (reset)
      step |=> (touch_seq_ff - $past(touch_seq_ff)) <= 32'd1)
      else $error("touch sequence jumped");
   a_touch_pop_only: assert property (@(posedge clock) disable iff (reset)
      touch_valid |-> op == riea_pkg::OP_POP_TOUCH)
      else $error("touch sample outside pop");
endmodule

// File: rtl/core/remote_input_event_aggregator.sv
// top level of the remote input aggregator: input register, config registers, result register
`timescale 1ns / 1ps
// Takes one word per cycle while the result side keeps up. A word is registered, then the state
// update and its result are computed from the input register into a result register, which
// raises rsp_valid; while the result side stalls, the word waits in the input register.
// Configuration writes are taken only while the input register is empty.
module remote_input_event_aggregator #(
   parameter int MASK_BITS  = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_opcode,
   input  logic [7:0]  req_bit_index,
   input  logic        req_is_pressed,
   input  logic signed [7:0] req_enc_steps,
   input  logic [1:0]  req_touch_event,
   input  logic signed [15:0] req_coord_x,
   input  logic signed [15:0] req_coord_y,
   input  logic [31:0] req_keys_level,
   input  logic [31:0] req_trims_level,
   input  logic        req_finger_down,
   input  logic [31:0] req_now_ms,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_mask_out,
   output logic signed [31:0] rsp_enc_offset,
   output logic [31:0] rsp_dt_out,
   output logic        rsp_touch_valid,
   output logic [14:0] rsp_touch_x_out,
   output logic [14:0] rsp_touch_y_out,
   output logic        rsp_touch_pressed,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   logic        in_vld_ff;
   logic [3:0]  op_ff;
   logic [7:0]  idx_ff;
   logic        prs_ff, fd_ff;
   logic signed [7:0] st_ff;
   logic [1:0]  ev_ff;
   logic signed [15:0] x_ff, y_ff;
   logic [31:0] kl_ff, tl_ff, now_ff;
   logic [15:0] rto_ff, edt_ff, sw_ff, sh_ff;
   logic        step, out_free;
   logic [31:0] m, d;
   logic signed [31:0] o;
   logic        tv;
   riea_pkg::sample_type ts;

   assign out_free  = !rsp_valid || rsp_ready;
   assign step      = in_vld_ff && out_free;
   assign req_ready = !in_vld_ff || out_free;
   assign csr_ready = !in_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) in_vld_ff <= 1'b0;
      else if (req_ready) in_vld_ff <= req_valid;
      if (req_ready && req_valid) begin
         op_ff <= req_opcode; idx_ff <= req_bit_index; prs_ff <= req_is_pressed;
         st_ff <= req_enc_steps; ev_ff <= req_touch_event; x_ff <= req_coord_x;
         y_ff <= req_coord_y; kl_ff <= req_keys_level; tl_ff <= req_trims_level;
         fd_ff <= req_finger_down; now_ff <= req_now_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rto_ff <= 16'd500; edt_ff <= 16'd200; sw_ff <= 16'd480; sh_ff <= 16'd272;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            riea_pkg::REG_RELEASE: rto_ff <= csr_data;
            riea_pkg::REG_ENC_DT:  edt_ff <= csr_data;
            riea_pkg::REG_WIDTH:   sw_ff  <= csr_data;
            riea_pkg::REG_HEIGHT:  sh_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   riea_core #(.MASK_BITS(MASK_BITS)) u_core (
      .clock(clock), .reset(reset), .step(step), .op(op_ff), .bit_index(idx_ff),
      .is_pressed(prs_ff), .enc_steps(st_ff), .touch_event(ev_ff), .coord_x(x_ff),
      .coord_y(y_ff), .keys_level(kl_ff), .trims_level(tl_ff), .finger_down(fd_ff),
      .now_ms(now_ff), .release_timeout_ms(rto_ff), .encoder_idle_dt_ms(edt_ff),
      .screen_width(sw_ff), .screen_height(sh_ff), .mask_out(m), .enc_offset(o),
      .dt_out(d), .touch_valid(tv), .touch_sample(ts));

   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else if (out_free) rsp_valid <= in_vld_ff;
      if (step) begin
         rsp_mask_out <= m; rsp_enc_offset <= o; rsp_dt_out <= d;
         rsp_touch_valid <= tv; rsp_touch_x_out <= ts.pt.x;
         rsp_touch_y_out <= ts.pt.y; rsp_touch_pressed <= ts.pressed;
      end
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_mask_out))
      else $error("result dropped while stalled");
   a_step_out: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid)
      else $error("processed word produced no result");
   a_touch_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_touch_valid) |-> (rsp_touch_x_out == 15'd0 && !rsp_touch_pressed))
      else $error("touch fields set without sample");
endmodule
